FILE: rtl/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned SymW       = 6;
  localparam int unsigned GroupW     = 24;
  localparam int unsigned HeldW      = 18;
  localparam int unsigned BytesPerGr = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CharW-1:0] CharPad  = 8'h3D;  // '='
  localparam logic [CharW-1:0] CharPass = 8'h23;  // '#'

  // one queued request: up to three bytes, high byte first, keep[2] for the high byte
  typedef struct packed {
    logic [GroupW-1:0]     data;
    logic [BytesPerGr-1:0] keep;
  } entry_t;

  typedef struct packed {
    logic            is_sym;
    logic [SymW-1:0] val;
  } sym_t;

  function automatic sym_t sym_decode(input logic [CharW-1:0] c);
    sym_t             s;
    logic [CharW-1:0] t;
    s = '0;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'd65;
      s.is_sym = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'd71;
      s.is_sym = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      s.is_sym = 1'b1;
    end else if (c == 8'h2B) begin
      t = 8'd62;
      s.is_sym = 1'b1;
    end else if (c == 8'h2F) begin
      t = 8'd63;
      s.is_sym = 1'b1;
    end else if (c == CharPad) begin
      t = 8'd0;
      s.is_sym = 1'b1;
    end
    s.val = t[SymW-1:0];
    return s;
  endfunction

endpackage

FILE: rtl/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [b64d_pkg::CharW-1:0]        char_i,
  output logic                              push_o,
  output b64d_pkg::entry_t                  entry_o
);

  logic [b64d_pkg::HeldW-1:0]  group_q, group_d;
  logic [1:0]                  count_q, count_d;
  b64d_pkg::sym_t              sym;
  logic [b64d_pkg::GroupW-1:0] word;
  logic                        is_pass;

  assign sym     = b64d_pkg::sym_decode(char_i);
  assign is_pass = (char_i == b64d_pkg::CharPass);
  assign word    = {group_q, sym.val};

  always_comb begin
    group_d = group_q;
    count_d = count_q;
    push_o  = 1'b0;
    entry_o = '0;
    if (accept_i) begin
      if (is_pass) begin
        push_o       = 1'b1;
        entry_o.data = {b64d_pkg::CharPass, 16'h0000};
        entry_o.keep = 3'b100;
      end else if (sym.is_sym) begin
        if (count_q != 2'd3) begin
          group_d = {group_q[b64d_pkg::HeldW-b64d_pkg::SymW-1:0], sym.val};
          count_d = count_q + 2'd1;
        end else begin
          entry_o.data = word;
          entry_o.keep = {word[23:16] != 8'h00, word[15:8] != 8'h00, word[7:0] != 8'h00};
          push_o       = |entry_o.keep;  // all-zero group gives nothing
          group_d      = '0;
          count_d      = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      count_q <= 2'd0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64d_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output b64d_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64d_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count out of range");
  a_no_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (entry_i.keep != '0))
    else $error("empty request queued");

endmodule

FILE: rtl/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  b64d_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       byte_o,
  output logic             last_o
);

  logic [b64d_pkg::GroupW-1:0]     data_q;
  logic [b64d_pkg::BytesPerGr-1:0] rem_q, rem_d, rem_next;
  logic                            fire;

  always_comb begin
    rem_next = 3'b000;
    byte_o   = data_q[7:0];
    if (rem_q[2]) begin
      byte_o   = data_q[23:16];
      rem_next = {1'b0, rem_q[1:0]};
    end else if (rem_q[1]) begin
      byte_o   = data_q[15:8];
      rem_next = {2'b00, rem_q[0]};
    end
  end

  assign valid_o = |rem_q;
  assign last_o  = (rem_next == 3'b000);
  assign fire    = valid_o && ready_i;
  assign pop_o   = !empty_i && (!valid_o || (fire && last_o));
  assign rem_d   = pop_o ? head_i.keep : (fire ? rem_next : rem_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> valid_o)
    else $error("loaded request shows no byte");
  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!valid_o || (ready_i && last_o)))
    else $error("request loaded over pending bytes");

endmodule

FILE: rtl/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// Base64 stream decoder.
// Input stream: one ASCII character per request on s_axis (tdata[7:0]).
// Output stream: one byte per request on m_axis (tdata[7:0]), tlast on the
// final byte caused by one input character.
// '#' is passed through as a single byte with tlast. Alphabet characters and
// '=' are gathered four at a time; the completed group gives its non-zero
// bytes, high first. Any other character is dropped.
// Throughput: one character per cycle in while the queue is not full, one
// byte per cycle out while bytes are waiting and m_axis_tready_i is high.
// The queue is written at the edge that accepts a '#' or a group's fourth
// character; the output stage loads from the queue once it is free.
// A small queue of Depth requests sits between the character front end and
// the byte serialiser; when m_axis stalls, s_axis keeps accepting until the
// queue is full, then s_axis_tready_o drops.
// Reset clears the partial group, the queue and the output stage; no
// clearing pass is needed.
module base64_stream_decoder_top #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_out
  output logic       m_axis_tlast_o    // last_of_run
);

  logic             full, empty, push, pop;
  b64d_pkg::entry_t entry, head;

  assign s_axis_tready_o = !full;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_axis_tvalid_i && s_axis_tready_o),
    .char_i   (s_axis_tdata_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  b64d_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .byte_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule

FILE: tb/sv/base64_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] char_in
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] byte_out
  logic       m_axis_tlast_o;   // last_of_run

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  out_byte_t   pending_bytes[$];
  logic [17:0] held_bits;
  logic [1:0]  held_count;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned mismatches;

  base64_stream_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit alpha_index(input logic [7:0] c, output logic [5:0] idx);
    idx = '0;
    for (int k = 0; k < 64; k++) begin
      if (b64_alpha[k] == c) begin
        idx = k[5:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // expected bytes for one accepted character
  function automatic void decode_char(input logic [7:0] c);
    logic [5:0]  v;
    logic [23:0] word;
    logic [7:0]  grp[3];
    int          n;
    n = 0;
    if (c == b64d_pkg::CharPass) begin
      pending_bytes.push_back('{data: b64d_pkg::CharPass, last: 1'b1});
      return;
    end
    if (c == b64d_pkg::CharPad) begin
      v = '0;
    end else if (!alpha_index(c, v)) begin
      return;
    end
    if (held_count != 2'd3) begin
      held_bits  = {held_bits[11:0], v};
      held_count = held_count + 2'd1;
      return;
    end
    word       = {held_bits, v};
    held_bits  = '0;
    held_count = '0;
    grp[0] = word[23:16];
    grp[1] = word[15:8];
    grp[2] = word[7:0];
    for (int k = 0; k < 3; k++) begin
      if (grp[k] != 8'h00) begin
        pending_bytes.push_back('{data: grp[k], last: 1'b0});
        n++;
      end
    end
    if (n > 0) pending_bytes[pending_bytes.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return "A";
    else if (r < 72) return b64_alpha[$urandom_range(63)];
    else if (r < 80) return b64d_pkg::CharPad;
    else if (r < 86) return b64d_pkg::CharPass;
    else return 8'($urandom_range(255));
  endfunction

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_char(c);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_char(rand_char());
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver side: random stalls, or a long hold-off when requested
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        hold_cycles     = hold_cycles - 1;
      end else begin
        m_axis_tready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %h last %b", m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== m_axis_tdata_o || want.last !== m_axis_tlast_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte exp %h last %b, got %h last %b",
                     want.data, want.last, m_axis_tdata_o, m_axis_tlast_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, "T", "W", 8'hFF, "F", "u",                    // foreign chars inside a group
            "A", "A", b64d_pkg::CharPass, "A", "B",              // pass-through mid group
            b64d_pkg::CharPad, b64d_pkg::CharPad,                // empty group
            b64d_pkg::CharPad, b64d_pkg::CharPad,
            "/", "/", "/", "/",
            8'h80, "z", "9", "+", "0", "a", "Z", 8'h40};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (seq[i]) send_char(seq[i]);
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_random(25);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 54;
    stall_pct     = 0;
    send_random(25);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 54;
    send_random(25);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 30;
    stall_pct     = 30;
    send_random(25);
    wait_drained();
  endtask

  // long receiver hold-off so the queue fills and s_axis stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 10;
    hold_cycles   = 150;
    send_random(30);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    stall_pct     = 20;
    send_random(10);
    wait_drained();
    send_random(10);
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    held_bits       = '0;
    held_count      = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_cycles     = 0;
    mismatches      = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    test_drain_pause();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
